@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define GQF_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property that is also checked during reset.
`define GQF_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ hw/rtl/gqf_pkg.sv @@
// Shared types, widths and codes for the grid set labeller.
// No dependencies.
package gqf_pkg;

   localparam int MAX_DIM_DEF = 8;
   localparam int CW  = 3;   // coordinate width
   localparam int LW  = 6;   // label width
   localparam int SW  = 4;   // size register width
   localparam int TW  = 2;   // request type width
   localparam int CIW = 2;   // csr index width

   localparam logic [TW-1:0] REQ_JOIN  = 2'd0;
   localparam logic [TW-1:0] REQ_QUERY = 2'd1;
   localparam logic [TW-1:0] REQ_FIND  = 2'd2;
   localparam logic [TW-1:0] REQ_ELEM  = 2'd3;

   localparam logic [CIW-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CIW-1:0] CSR_HEIGHT = 2'd1;

   typedef struct packed {
      logic          en;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
   } cell_acc_type;

   typedef struct packed {
      logic          en;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [LW-1:0] lbl;
   } cell_wr_type;

   typedef struct packed {
      logic          vld;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [LW-1:0] lbl;
   } cell_rd_type;

   function automatic logic in_grid(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                    input logic [SW-1:0] w, input logic [SW-1:0] h);
      return (SW'(x) < w) && (SW'(y) < h);
   endfunction

endpackage

@@ hw/rtl/gqf_store.sv @@
// Label memory: one write and one registered read per cycle.
// Per-entry valid bits give the initial label x*height+y until written.
// Depends on gqf_pkg.
module gqf_store import gqf_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic [SW-1:0] eff_h,
   input  logic          adv,
   input  cell_acc_type  rd_req,
   input  cell_wr_type   wr_req,
   output cell_rd_type   rd_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [LW-1:0]    mem [DEPTH];
   logic [LW-1:0]    mem_q_ff;
   logic [DEPTH-1:0] vld_ff;
   logic             dv_ff;
   logic             sv_ff;
   logic [CW-1:0]    dx_ff;
   logic [CW-1:0]    dy_ff;
   logic [AW-1:0]    raddr;
   logic [AW-1:0]    waddr;
   logic [CW+SW-1:0] prod;
   logic [CW+SW-1:0] dflt;

   assign raddr = AW'(int'(rd_req.x) * MAX_DIM + int'(rd_req.y));
   assign waddr = AW'(int'(wr_req.x) * MAX_DIM + int'(wr_req.y));

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[waddr] <= wr_req.lbl;
      end
      if (rd_req.en) begin
         mem_q_ff <= mem[raddr];
         sv_ff    <= vld_ff[raddr];
         dx_ff    <= rd_req.x;
         dy_ff    <= rd_req.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (wr_req.en) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else if (adv) begin
         dv_ff <= rd_req.en;
      end
   end

   assign prod = {{SW{1'b0}}, dx_ff} * {{CW{1'b0}}, eff_h};
   assign dflt = prod + {{SW{1'b0}}, dy_ff};

   assign rd_data.vld = dv_ff;
   assign rd_data.x   = dx_ff;
   assign rd_data.y   = dy_ff;
   assign rd_data.lbl = sv_ff ? mem_q_ff : dflt[LW-1:0];

endmodule

@@ hw/rtl/gqf_ctrl.sv @@
// Request sequencer: label reads, relabel and list scans, result register.
// Depends on gqf_pkg; drives gqf_store.
module gqf_ctrl import gqf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [SW-1:0] eff_w,
   input  logic [SW-1:0] eff_h,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [TW-1:0] req_type,
   input  logic [CW-1:0] req_first_x,
   input  logic [CW-1:0] req_first_y,
   input  logic [CW-1:0] req_second_x,
   input  logic [CW-1:0] req_second_y,
   input  logic [LW-1:0] req_query_label,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_status,
   output logic          rsp_joined,
   output logic [LW-1:0] rsp_label,
   output logic [CW-1:0] rsp_cell_x,
   output logic [CW-1:0] rsp_cell_y,
   output logic          rsp_cell_valid,
   output logic          rsp_last,
   output logic          adv,
   output cell_acc_type  rd_req,
   output cell_wr_type   wr_req,
   input  cell_rd_type   rd_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RDA  = 3'd1;
   localparam logic [2:0] ST_RDB  = 3'd2;
   localparam logic [2:0] ST_WB   = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [TW-1:0] kind_ff, kind_in;
   logic [CW-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic [LW-1:0] q_ff, q_in, la_ff, la_in, lb_ff, lb_in;
   logic          bad_ff, bad_in;
   logic [CW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic          iss_done_ff, iss_done_in;
   logic          pend_v_ff, pend_v_in;
   logic [CW-1:0] px_ff, px_in, py_ff, py_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_status_ff, rsp_status_in;
   logic          rsp_joined_ff, rsp_joined_in;
   logic [LW-1:0] rsp_label_ff, rsp_label_in;
   logic [CW-1:0] rsp_cell_x_ff, rsp_cell_x_in;
   logic [CW-1:0] rsp_cell_y_ff, rsp_cell_y_in;
   logic          rsp_cell_valid_ff, rsp_cell_valid_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          load_out;
   logic          out_free;
   logic          q_match;
   logic          issue;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_match  = rd_data.vld && (rd_data.lbl == q_ff);
   assign adv      = !(state_ff == ST_SCAN && kind_ff == REQ_ELEM && q_match &&
                       pend_v_ff && !out_free);
   assign issue    = (state_ff == ST_RDA) || (state_ff == ST_RDB) ||
                     (state_ff == ST_SCAN && !iss_done_ff);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      rd_req.en = issue && adv;
      rd_req.x  = sx_ff;
      rd_req.y  = sy_ff;
      if (state_ff == ST_RDA) begin
         rd_req.x = ax_ff;
         rd_req.y = ay_ff;
      end else if (state_ff == ST_RDB) begin
         rd_req.x = bx_ff;
         rd_req.y = by_ff;
      end
   end

   assign wr_req.en  = (state_ff == ST_SCAN) && (kind_ff == REQ_JOIN) && rd_data.vld &&
                       (rd_data.lbl == lb_ff);
   assign wr_req.x   = rd_data.x;
   assign wr_req.y   = rd_data.y;
   assign wr_req.lbl = la_ff;

   always_comb begin
      state_in          = state_ff;
      kind_in           = kind_ff;
      ax_in             = ax_ff;
      ay_in             = ay_ff;
      bx_in             = bx_ff;
      by_in             = by_ff;
      q_in              = q_ff;
      la_in             = la_ff;
      lb_in             = lb_ff;
      bad_in            = bad_ff;
      sx_in             = sx_ff;
      sy_in             = sy_ff;
      iss_done_in       = iss_done_ff;
      pend_v_in         = pend_v_ff;
      px_in             = px_ff;
      py_in             = py_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      load_out          = 1'b0;
      rsp_status_in     = 1'b0;
      rsp_joined_in     = 1'b0;
      rsp_label_in      = '0;
      rsp_cell_x_in     = '0;
      rsp_cell_y_in     = '0;
      rsp_cell_valid_in = 1'b0;
      rsp_last_in       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in     = req_type;
               ax_in       = req_first_x;
               ay_in       = req_first_y;
               bx_in       = (req_type == REQ_FIND) ? req_first_x : req_second_x;
               by_in       = (req_type == REQ_FIND) ? req_first_y : req_second_y;
               q_in        = req_query_label;
               bad_in      = (req_type != REQ_ELEM) &&
                             !(in_grid(req_first_x, req_first_y, eff_w, eff_h) &&
                               ((req_type == REQ_FIND) ||
                                in_grid(req_second_x, req_second_y, eff_w, eff_h)));
               sx_in       = '0;
               sy_in       = '0;
               iss_done_in = 1'b0;
               pend_v_in   = 1'b0;
               if (req_type == REQ_ELEM) begin
                  state_in = ST_SCAN;
               end else if (bad_in) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RDA;
               end
            end
         end
         ST_RDA: begin
            state_in = ST_RDB;
         end
         ST_RDB: begin
            la_in    = rd_data.lbl;
            state_in = ST_WB;
         end
         ST_WB: begin
            lb_in    = rd_data.lbl;
            state_in = (kind_ff == REQ_JOIN) ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (rd_req.en) begin
               if (SW'(sy_ff) == eff_h - SW'(1)) begin
                  sy_in = '0;
                  if (SW'(sx_ff) == eff_w - SW'(1)) begin
                     iss_done_in = 1'b1;
                  end else begin
                     sx_in = sx_ff + CW'(1);
                  end
               end else begin
                  sy_in = sy_ff + CW'(1);
               end
            end
            if (kind_ff == REQ_ELEM && q_match && adv) begin
               if (pend_v_ff) begin
                  load_out          = 1'b1;
                  rsp_cell_x_in     = px_ff;
                  rsp_cell_y_in     = py_ff;
                  rsp_cell_valid_in = 1'b1;
               end
               pend_v_in = 1'b1;
               px_in     = rd_data.x;
               py_in     = rd_data.y;
            end
            if (iss_done_ff && !rd_data.vld) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_out          = 1'b1;
               rsp_last_in       = 1'b1;
               rsp_status_in     = bad_ff;
               rsp_joined_in     = (kind_ff == REQ_QUERY) && !bad_ff && (la_ff == lb_ff);
               rsp_label_in      = ((kind_ff == REQ_FIND) && !bad_ff) ? la_ff : '0;
               if (kind_ff == REQ_ELEM && pend_v_ff) begin
                  rsp_cell_x_in     = px_ff;
                  rsp_cell_y_in     = py_ff;
                  rsp_cell_valid_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         iss_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_v_ff    <= pend_v_in;
         iss_done_ff  <= iss_done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      q_ff    <= q_in;
      la_ff   <= la_in;
      lb_ff   <= lb_in;
      bad_ff  <= bad_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      if (load_out) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_joined_ff     <= rsp_joined_in;
         rsp_label_ff      <= rsp_label_in;
         rsp_cell_x_ff     <= rsp_cell_x_in;
         rsp_cell_y_ff     <= rsp_cell_y_in;
         rsp_cell_valid_ff <= rsp_cell_valid_in;
         rsp_last_ff       <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_joined     = rsp_joined_ff;
   assign rsp_label      = rsp_label_ff;
   assign rsp_cell_x     = rsp_cell_x_ff;
   assign rsp_cell_y     = rsp_cell_y_ff;
   assign rsp_cell_valid = rsp_cell_valid_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ hw/rtl/grid_quick_find_union_find_top.sv @@
// Grid set labeller (quick-find). Each cell of a W x H grid (W, H up to MAX_DIM) holds a
// set label in a label memory with one registered read per cycle; after reset or any size
// write every cell reads as x*H+y, with no clearing pass (per-entry valid bits). A find or
// joined query reads its first cell, then its second, then loads its result; a request with
// a coordinate outside the grid loads its result without a read. A join scans the active
// grid at one memory read per cycle. An elements request lists matching cells as it scans;
// the scan halts while a listed cell waits on a stalled result channel, and the final
// result may also wait there. One request is in work at a time; the next is accepted the
// cycle after the previous result is loaded, even while that result waits in the result
// register.
// Depends on gqf_pkg, gqf_ctrl, gqf_store.
module grid_quick_find_union_find_top import gqf_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [CIW-1:0] csr_index,
   input  logic [SW-1:0]  csr_wdata,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [TW-1:0]  req_type,
   input  logic [CW-1:0]  req_first_x,
   input  logic [CW-1:0]  req_first_y,
   input  logic [CW-1:0]  req_second_x,
   input  logic [CW-1:0]  req_second_y,
   input  logic [LW-1:0]  req_query_label,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_status,
   output logic           rsp_joined,
   output logic [LW-1:0]  rsp_label,
   output logic [CW-1:0]  rsp_cell_x,
   output logic [CW-1:0]  rsp_cell_y,
   output logic           rsp_cell_valid,
   output logic           rsp_last
);

   localparam logic [SW-1:0] MAX_S = SW'(MAX_DIM);

   logic [SW-1:0] width_ff;
   logic [SW-1:0] height_ff;
   logic [SW-1:0] eff_w;
   logic [SW-1:0] eff_h;
   logic          clear;
   logic          adv;
   cell_acc_type  rd_req;
   cell_wr_type   wr_req;
   cell_rd_type   rd_data;

   always_comb begin
      clear = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  clear = 1'b1;
            CSR_HEIGHT: clear = 1'b1;
            default:    clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SW'(8);
         height_ff <= SW'(8);
      end else if (csr_we) begin
         if (csr_index == CSR_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_index == CSR_HEIGHT) begin
            height_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      if (width_ff == '0 || height_ff == '0) begin
         eff_w = MAX_S;
         eff_h = MAX_S;
      end else begin
         eff_w = (width_ff > MAX_S) ? MAX_S : width_ff;
         eff_h = (height_ff > MAX_S) ? MAX_S : height_ff;
      end
   end

   gqf_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .eff_w           (eff_w),
      .eff_h           (eff_h),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_second_x    (req_second_x),
      .req_second_y    (req_second_y),
      .req_query_label (req_query_label),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_joined      (rsp_joined),
      .rsp_label       (rsp_label),
      .rsp_cell_x      (rsp_cell_x),
      .rsp_cell_y      (rsp_cell_y),
      .rsp_cell_valid  (rsp_cell_valid),
      .rsp_last        (rsp_last),
      .adv             (adv),
      .rd_req          (rd_req),
      .wr_req          (wr_req),
      .rd_data         (rd_data)
   );

   gqf_store #(
      .MAX_DIM (MAX_DIM)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .eff_h   (eff_h),
      .adv     (adv),
      .rd_req  (rd_req),
      .wr_req  (wr_req),
      .rd_data (rd_data)
   );

endmodule

@@ hw/rtl/gqf_checker.sv @@
// Port-level checks on the result channel of the grid set labeller.
// Depends on gqf_pkg and assert_macros.svh; bound to the top level.
`include "assert_macros.svh"

module gqf_checker import gqf_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic          rsp_status,
   input logic          rsp_joined,
   input logic [LW-1:0] rsp_label,
   input logic [CW-1:0] rsp_cell_x,
   input logic [CW-1:0] rsp_cell_y,
   input logic          rsp_cell_valid,
   input logic          rsp_last
);

   // stalled transfer holds its payload
   `GQF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable(rsp_status) && $stable(rsp_joined) && $stable(rsp_label) &&
      $stable(rsp_cell_x) && $stable(rsp_cell_y) && $stable(rsp_cell_valid) &&
      $stable(rsp_last))

   `GQF_ASSERT(a_member_clean, clock, reset, rsp_valid && rsp_cell_valid |-> !rsp_status && !rsp_joined && rsp_label == '0)

   `GQF_ASSERT(a_more_is_member, clock, reset, rsp_valid && !rsp_last |-> rsp_cell_valid)

   `GQF_ASSERT(a_error_single, clock, reset, rsp_valid && rsp_status |-> rsp_last && !rsp_cell_valid && !rsp_joined)

   `GQF_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)

endmodule

bind grid_quick_find_union_find_top gqf_checker u_gqf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_joined     (rsp_joined),
   .rsp_label      (rsp_label),
   .rsp_cell_x     (rsp_cell_x),
   .rsp_cell_y     (rsp_cell_y),
   .rsp_cell_valid (rsp_cell_valid),
   .rsp_last       (rsp_last)
);
